// ----- hdl/sbp_pkg.sv -----
// Shared constants, types and codes of the skyline box placer.
package sbp_pkg;
	localparam int MaxCols = 256;
	localparam int ColW = $clog2(MaxCols);
	localparam int CntW = $clog2(MaxCols + 1);
	localparam int DepthW = 16;

	localparam logic [0:0] REG_BIN_WIDTH = 1'b0;
	localparam logic [0:0] REG_BIN_HEIGHT = 1'b1;
	localparam logic ACT_PLACE = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		OP_HOLD, OP_LOAD, OP_WIN, OP_SCAN, OP_WRITE, OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic [ColW-1:0] wr_lo;
		logic [CntW:0] wr_end;
		logic [DepthW-1:0] wr_val;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_WIN, S_SCAN, S_WRITE, S_OUT
	} state_t;
endpackage

// ----- hdl/sbp_if.sv -----
// Channel interfaces of the skyline box placer.
interface sbp_req_if;
	logic valid;
	logic ready;
	logic action;
	logic [8:0] box_width;
	logic [15:0] box_height;
	modport source(output valid, action, box_width, box_height, input ready);
	modport sink(input valid, action, box_width, box_height, output ready);
endinterface

interface sbp_rsp_if;
	logic valid;
	logic ready;
	logic placed;
	logic [7:0] x_position;
	logic [15:0] y_position;
	modport source(output valid, placed, x_position, y_position, input ready);
	modport sink(input valid, placed, x_position, y_position, output ready);
endinterface

interface sbp_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/sbp_cell.sv -----
// One skyline column with its window maximum and shift registers.
module sbp_cell (
	input logic clk,
	input logic arst_n,
	input sbp_pkg::cell_ctl_t ctl,
	input logic [sbp_pkg::ColW-1:0] idx,
	input logic [sbp_pkg::DepthW-1:0] t_in,
	input logic [sbp_pkg::DepthW-1:0] m_in,
	output logic [sbp_pkg::DepthW-1:0] t,
	output logic [sbp_pkg::DepthW-1:0] m
);
	logic [sbp_pkg::DepthW-1:0] sky_q, t_q, m_q;
	logic hit;

	assign hit = (idx >= ctl.wr_lo) &&
		({{(sbp_pkg::CntW + 1 - sbp_pkg::ColW){1'b0}}, idx} < ctl.wr_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sky_q <= '0;
		end else if (ctl.op == sbp_pkg::OP_CLEAR) begin
			sky_q <= '0;
		end else if (ctl.op == sbp_pkg::OP_WRITE && hit) begin
			sky_q <= ctl.wr_val;
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			sbp_pkg::OP_LOAD: begin
				t_q <= sky_q;
				m_q <= '0;
			end
			sbp_pkg::OP_WIN: begin
				t_q <= t_in;
				m_q <= (t_q > m_q) ? t_q : m_q;
			end
			sbp_pkg::OP_SCAN: m_q <= m_in;
			default: ;
		endcase
	end

	assign t = t_q;
	assign m = m_q;
endmodule

// ----- hdl/skyline_box_placer.sv -----
// Top level of the skyline box placer: control sequencer and row of column cells.
//  channel | dir | transfer when
//  req     | in  | req.valid && req.ready
//  rsp     | out | rsp.valid && rsp.ready
//  cfg     | in  | cfg.valid && cfg.ready
// A place request loads the cells, then box_width shift steps build every window
// maximum in the cells, then the scan shifts them out of cell zero one window at a
// time. A clear or a rejected width goes straight to the output state.
// Reset zeroes the skyline at once. A waiting result blocks only the next result.
module skyline_box_placer (
	input logic clk,
	input logic arst_n,
	sbp_req_if.sink req,
	sbp_rsp_if.source rsp,
	sbp_cfg_if.sink cfg
);
	localparam int N = sbp_pkg::MaxCols;
	localparam int DW = sbp_pkg::DepthW;
	localparam int CW = sbp_pkg::CntW;

	sbp_pkg::state_t state_q, state_d;
	sbp_pkg::cell_ctl_t ctl;
	logic [8:0] bin_width_q;
	logic [DW-1:0] bin_height_q;
	logic [CW-1:0] bw_q, cols_q, k_q, c_q, nw_q;
	logic [DW-1:0] bh_q, best_q;
	logic found_q;
	logic res_placed_q;
	logic [7:0] res_x_q;
	logic [DW-1:0] res_y_q;
	logic [CW-1:0] best_x_q;
	logic ov_q, op_q;
	logic [7:0] ox_q;
	logic [DW-1:0] oy_q;
	logic [DW-1:0] t_w [0:N];
	logic [DW-1:0] m_w [0:N];
	logic [CW-1:0] cols_cap;
	logic accept, take, fits;
	logic [DW:0] top;

	assign t_w[N] = '0;
	assign m_w[N] = '0;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			sbp_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl),
				.idx(sbp_pkg::ColW'(g)),
				.t_in(t_w[g+1]), .m_in(m_w[g+1]),
				.t(t_w[g]), .m(m_w[g])
			);
		end
	endgenerate

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == sbp_pkg::S_IDLE);
	assign accept = req.valid && req.ready;
	assign take = !ov_q || rsp.ready;
	assign cols_cap = (bin_width_q > 9'(N)) ? CW'(N) : CW'(bin_width_q);
	assign top = {1'b0, best_q} + {1'b0, bh_q};
	assign fits = found_q && (top <= {1'b0, bin_height_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q <= 9'd256;
			bin_height_q <= 16'hFFFF;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				sbp_pkg::REG_BIN_WIDTH: bin_width_q <= cfg.data[8:0];
				sbp_pkg::REG_BIN_HEIGHT: bin_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbp_pkg::S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sbp_pkg::S_OUT && take) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sbp_pkg::S_IDLE: begin
				bw_q <= req.box_width;
				bh_q <= req.box_height;
				cols_q <= cols_cap;
				res_placed_q <= 1'b0;
				res_x_q <= '0;
				res_y_q <= '0;
			end
			sbp_pkg::S_LOAD: begin
				k_q <= bw_q;
				nw_q <= cols_q - bw_q;
				c_q <= '0;
				found_q <= 1'b0;
			end
			sbp_pkg::S_WIN: k_q <= k_q - 1'b1;
			sbp_pkg::S_SCAN: begin
				c_q <= c_q + 1'b1;
				if (m_w[0] < bin_height_q && (!found_q || m_w[0] < best_q)) begin
					found_q <= 1'b1;
					best_q <= m_w[0];
					best_x_q <= c_q;
				end
			end
			sbp_pkg::S_WRITE: begin
				res_placed_q <= fits;
				res_x_q <= fits ? best_x_q[7:0] : 8'd0;
				res_y_q <= fits ? best_q : '0;
			end
			default: ;
		endcase
		if (state_q == sbp_pkg::S_OUT && take) begin
			op_q <= res_placed_q;
			ox_q <= res_x_q;
			oy_q <= res_y_q;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl.op = sbp_pkg::OP_HOLD;
		ctl.wr_lo = best_x_q[sbp_pkg::ColW-1:0];
		ctl.wr_end = {1'b0, best_x_q} + {1'b0, bw_q};
		ctl.wr_val = top[DW-1:0];
		case (state_q)
			sbp_pkg::S_IDLE: begin
				if (accept) begin
					if (req.action == sbp_pkg::ACT_CLEAR) begin
						ctl.op = sbp_pkg::OP_CLEAR;
						state_d = sbp_pkg::S_OUT;
					end else if (req.box_width == '0 || req.box_width > 9'(cols_cap)) begin
						state_d = sbp_pkg::S_OUT;
					end else begin
						state_d = sbp_pkg::S_LOAD;
					end
				end
			end
			sbp_pkg::S_LOAD: begin
				ctl.op = sbp_pkg::OP_LOAD;
				state_d = sbp_pkg::S_WIN;
			end
			sbp_pkg::S_WIN: begin
				ctl.op = sbp_pkg::OP_WIN;
				if (k_q == CW'(1)) state_d = sbp_pkg::S_SCAN;
			end
			sbp_pkg::S_SCAN: begin
				ctl.op = sbp_pkg::OP_SCAN;
				if (c_q == nw_q) state_d = sbp_pkg::S_WRITE;
			end
			sbp_pkg::S_WRITE: begin
				if (fits) ctl.op = sbp_pkg::OP_WRITE;
				state_d = sbp_pkg::S_OUT;
			end
			sbp_pkg::S_OUT: begin
				if (take) state_d = sbp_pkg::S_IDLE;
			end
			default: state_d = sbp_pkg::S_IDLE;
		endcase
	end

	assign rsp.valid = ov_q;
	assign rsp.placed = op_q;
	assign rsp.x_position = ox_q;
	assign rsp.y_position = oy_q;

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != sbp_pkg::S_IDLE)
		else $error("accepted request did not start work");
	a_win_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbp_pkg::S_WIN |-> k_q != '0)
		else $error("window step with zero count");
	a_placed_below: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.placed |-> rsp.y_position < bin_height_q)
		else $error("placed box rests at or above bin height");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbp_pkg::S_SCAN |-> c_q <= nw_q)
		else $error("scan ran past the last window");
endmodule

// ----- test/sbp_checker.sv -----
// Checker that predicts every skyline placement result and compares it with the block's output.
`timescale 1ns / 100ps
module sbp_checker (
	input logic clk,
	input logic arst_n,
	sbp_req_if req,
	sbp_rsp_if rsp,
	sbp_cfg_if cfg,
	output int fail_count,
	output int pending,
	output int placed_count,
	output int result_count
);
	typedef struct packed {
		logic placed;
		logic [7:0] x_position;
		logic [15:0] y_position;
	} placement_t;

	logic [15:0] depth_of[sbp_pkg::MaxCols];
	logic [8:0] cols_in_use;
	logic [15:0] height_limit;
	placement_t placements_due[$];

	function automatic placement_t place_box(input logic act, input logic [8:0] bw,
			input logic [15:0] bh);
		placement_t res;
		int cols;
		int hi;
		int best_x;
		int best_y;
		bit found;
		res = '0;
		found = 0;
		best_x = 0;
		best_y = 0;
		if (act == sbp_pkg::ACT_CLEAR) begin
			foreach (depth_of[i]) depth_of[i] = '0;
			return res;
		end
		cols = (cols_in_use > sbp_pkg::MaxCols) ? sbp_pkg::MaxCols : cols_in_use;
		if (bw == 0 || bw > cols)
			return res;
		for (int c = 0; c + bw <= cols; c++) begin
			hi = 0;
			for (int k = 0; k < bw; k++)
				if (depth_of[c + k] > hi)
					hi = depth_of[c + k];
			if (hi < height_limit && (!found || hi < best_y)) begin
				found = 1;
				best_x = c;
				best_y = hi;
			end
		end
		if (!found || best_y + bh > height_limit)
			return res;
		for (int k = 0; k < bw; k++)
			depth_of[best_x + k] = 16'(best_y + bh);
		res.placed = 1'b1;
		res.x_position = best_x[7:0];
		res.y_position = best_y[15:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placement_t due;
		placement_t got;
		if (!arst_n) begin
			foreach (depth_of[i]) depth_of[i] = '0;
			cols_in_use = 9'd256;
			height_limit = 16'hFFFF;
			placements_due.delete();
			fail_count = 0;
			pending = 0;
			placed_count = 0;
			result_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == sbp_pkg::REG_BIN_WIDTH)
					cols_in_use = cfg.data[8:0];
				else
					height_limit = cfg.data;
			end
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.placed, rsp.x_position, rsp.y_position};
				result_count++;
				if (placements_due.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count++;
				end else begin
					due = placements_due.pop_front();
					if (due.placed !== got.placed) begin
						$display("%0t: placed expected %0d actual %0d", $time, due.placed,
							got.placed);
						fail_count++;
					end
					if (due.x_position !== got.x_position) begin
						$display("%0t: x_position expected %0d actual %0d", $time,
							due.x_position, got.x_position);
						fail_count++;
					end
					if (due.y_position !== got.y_position) begin
						$display("%0t: y_position expected %0d actual %0d", $time,
							due.y_position, got.y_position);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				due = place_box(req.action, req.box_width, req.box_height);
				if (due.placed)
					placed_count++;
				placements_due.insert(placements_due.size(), due);
			end
			pending = placements_due.size();
		end
	end
endmodule

// ----- test/tb.sv -----
// Testbench top: drives requests, configuration and result stalls, and gives the verdict.
`timescale 1ns / 100ps
module tb;
	localparam int CycleLimit = 2_000_000;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending;
	int placed_count;
	int result_count;
	int cycle_count = 0;
	int accepted;
	bit stall_free;
	bit hold_off;

	sbp_req_if req();
	sbp_rsp_if rsp();
	sbp_cfg_if cfg();

	skyline_box_placer u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));
	sbp_checker u_checker (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.fail_count(fail_count), .pending(pending), .placed_count(placed_count),
		.result_count(result_count));

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_off)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= stall_free || ($urandom_range(99) >= 15);
	end

	task automatic send_box(input logic act, input logic [8:0] bw, input logic [15:0] bh);
		while (!stall_free && $urandom_range(99) < 15)
			@(posedge clk);
		req.valid <= 1'b1;
		req.action <= act;
		req.box_width <= bw;
		req.box_height <= bh;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		accepted++;
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_boxes(input int count, input int max_w, input int max_h);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 3)
				send_box(sbp_pkg::ACT_CLEAR, 9'($urandom), 16'($urandom));
			else if (r < 8)
				send_box(sbp_pkg::ACT_PLACE, 9'($urandom), 16'($urandom));
			else
				send_box(sbp_pkg::ACT_PLACE, 9'($urandom_range(max_w, 1)),
					16'($urandom_range(max_h)));
		end
	endtask

	initial begin
		accepted = 0;
		stall_free = 1'b0;
		hold_off = 1'b0;
		req.valid = 1'b0;
		req.action = sbp_pkg::ACT_PLACE;
		req.box_width = '0;
		req.box_height = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = sbp_pkg::REG_BIN_WIDTH;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_box(sbp_pkg::ACT_PLACE, 9'd256, 16'd10);
		send_box(sbp_pkg::ACT_PLACE, 9'd1, 16'd0);
		send_box(sbp_pkg::ACT_PLACE, 9'd1, 16'hFFFF);
		send_box(sbp_pkg::ACT_PLACE, 9'd0, 16'd5);
		send_box(sbp_pkg::ACT_PLACE, 9'd257, 16'd5);
		send_box(sbp_pkg::ACT_PLACE, 9'h1FF, 16'd5);
		send_box(sbp_pkg::ACT_PLACE, 9'd3, 16'd7);
		send_box(sbp_pkg::ACT_CLEAR, 9'h1FF, 16'hFFFF);
		send_box(sbp_pkg::ACT_PLACE, 9'd255, 16'd1);
		send_box(sbp_pkg::ACT_PLACE, 9'd1, 16'd2);
		send_box(sbp_pkg::ACT_PLACE, 9'd128, 16'hFFFE);
		drain();
		write_reg(sbp_pkg::REG_BIN_HEIGHT, 16'd20);
		write_reg(sbp_pkg::REG_BIN_WIDTH, 16'd8);
		send_box(sbp_pkg::ACT_PLACE, 9'd2, 16'd20);
		send_box(sbp_pkg::ACT_PLACE, 9'd2, 16'd21);
		send_box(sbp_pkg::ACT_PLACE, 9'd9, 16'd1);
		send_box(sbp_pkg::ACT_PLACE, 9'd8, 16'd0);
		send_box(sbp_pkg::ACT_PLACE, 9'd3, 16'd5);
		drain();
		write_reg(sbp_pkg::REG_BIN_WIDTH, 16'h01FF);
		write_reg(sbp_pkg::REG_BIN_HEIGHT, 16'd0);
		send_box(sbp_pkg::ACT_PLACE, 9'd1, 16'd0);
		drain();
		write_reg(sbp_pkg::REG_BIN_WIDTH, 16'd0);
		write_reg(sbp_pkg::REG_BIN_HEIGHT, 16'hFFFF);
		send_box(sbp_pkg::ACT_PLACE, 9'd1, 16'd1);
		send_box(sbp_pkg::ACT_CLEAR, 9'd0, 16'd0);
		drain();

		write_reg(sbp_pkg::REG_BIN_WIDTH, 16'd16);
		write_reg(sbp_pkg::REG_BIN_HEIGHT, 16'd60);
		hold_off = 1'b1;
		fork
			random_boxes(40, 6, 12);
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		random_boxes(300, 6, 12);
		drain();

		write_reg(sbp_pkg::REG_BIN_WIDTH, 16'd1);
		write_reg(sbp_pkg::REG_BIN_HEIGHT, 16'd30);
		random_boxes(60, 2, 8);
		drain();

		write_reg(sbp_pkg::REG_BIN_WIDTH, 16'd40);
		write_reg(sbp_pkg::REG_BIN_HEIGHT, 16'd200);
		stall_free = 1'b1;
		random_boxes(250, 12, 40);
		stall_free = 1'b0;
		drain();

		write_reg(sbp_pkg::REG_BIN_WIDTH, 16'd256);
		write_reg(sbp_pkg::REG_BIN_HEIGHT, 16'hFFFF);
		random_boxes(100, 256, 65535);
		drain();

		write_reg(sbp_pkg::REG_BIN_WIDTH, 16'd12);
		write_reg(sbp_pkg::REG_BIN_HEIGHT, 16'd40);
		random_boxes(390, 5, 10);
		drain();

		$display("Ran %0d requests with %0d results, %0d boxes placed.", accepted,
			result_count, placed_count);
		$display("Bin widths 0 to 511 and heights 0 to 65535 were used, with clears and stalls.");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ----- files.f -----
hdl/sbp_pkg.sv
hdl/sbp_if.sv
hdl/sbp_cell.sv
hdl/skyline_box_placer.sv
test/sbp_checker.sv
test/tb.sv
